// ===== design/toeq_pkg.sv =====
// Shared types, constants and helpers for the time-ordered event queue.
package toeq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int ID_BITS      = 8;
   localparam int REMOVE_LIMIT = 2;
   localparam int IDX_W        = $clog2(QUEUE_DEPTH);
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ID_BITS-1:0] id_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INSERT,
      ST_REMOVE,
      ST_REPORT
   } ctl_state_type;

   typedef struct packed {
      logic [31:0] due_time;
      logic [1:0]  direction;
      id_type      object;
   } slot_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  removed_count;
      logic        head_valid;
      logic [31:0] head_time;
      logic [1:0]  head_direction;
      logic [7:0]  head_object;
      logic [4:0]  entry_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic scan_step;
      logic insert_here;
      logic drop_here;
      logic set_full;
      logic set_empty;
      logic report;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type op;
      logic       req_valid;
      logic       full;
      logic       empty;
      logic       at_end;
      logic       time_before;
      logic       id_match;
      logic       limit_hit;
      logic       out_free;
   } sts_type;

   function automatic id_type port_to_id(input logic [7:0] value);
      logic [15:0] wide;
      wide = {8'd0, value};
      return wide[ID_BITS-1:0];
   endfunction

   function automatic logic [7:0] id_to_port(input id_type value);
      logic [15:0] wide;
      wide = 16'(value);
      return wide[7:0];
   endfunction

endpackage

// ===== design/toeq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface toeq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] event_time;
   logic [1:0]  direction;
   logic [7:0]  object_id;

   modport source (output valid, opcode, event_time, direction, object_id, input ready);
   modport sink   (input valid, opcode, event_time, direction, object_id, output ready);
endinterface

interface toeq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  removed_count;
   logic        head_valid;
   logic [31:0] head_time;
   logic [1:0]  head_direction;
   logic [7:0]  head_object;
   logic [4:0]  entry_count;

   modport source (output valid, status, removed_count, head_valid, head_time,
                   head_direction, head_object, entry_count, input ready);
   modport sink   (input valid, status, removed_count, head_valid, head_time,
                   head_direction, head_object, entry_count, output ready);
endinterface

// ===== design/toeq_datapath.sv =====
// Slot storage, scan index, operation registers and response register.
module toeq_datapath
   import toeq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   toeq_req_if.sink      req_ch,
   toeq_rsp_if.source    rsp_ch,
   input  cmd_type       cmd,
   output sts_type       sts
);

   logic        accept;
   opcode_type  op_ff;
   logic [31:0] time_ff;
   logic [1:0]  dir_ff;
   id_type      id_ff;
   cnt_type     scan_ff, scan_in;
   cnt_type     count_ff, count_in;
   logic [1:0]  removed_ff, removed_in;
   status_type  status_ff, status_in;
   slot_type    slot_ff [QUEUE_DEPTH];
   slot_type    slot_in [QUEUE_DEPTH];
   slot_type    new_slot;
   slot_type    cur_slot;
   idx_type     idx;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   assign req_ch.ready = cmd.take_req;
   assign accept       = req_ch.valid && cmd.take_req;
   assign idx          = scan_ff[IDX_W-1:0];
   assign cur_slot     = slot_ff[idx];
   assign new_slot     = '{due_time: time_ff, direction: dir_ff, object: id_ff};

   // latch the request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= opcode_type'(req_ch.opcode);
         time_ff <= req_ch.event_time;
         dir_ff  <= req_ch.direction;
         id_ff   <= port_to_id(req_ch.object_id);
      end
   end

   always_comb begin
      scan_in    = scan_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      if (accept) begin
         scan_in    = '0;
         removed_in = '0;
         status_in  = STS_OK;
      end
      if (cmd.scan_step)   scan_in = scan_ff + 1'b1;
      if (cmd.insert_here) count_in = count_ff + 1'b1;
      if (cmd.drop_here) begin
         count_in   = count_ff - 1'b1;
         removed_in = removed_ff + 1'b1;
      end
      if (cmd.set_full)  status_in = STS_FULL;
      if (cmd.set_empty) status_in = STS_EMPTY;
   end

   // shift-insert opens a gap at idx, drop closes the gap at idx
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         slot_in[k] = slot_ff[k];
         if (cmd.insert_here && IDX_W'(k) == idx) slot_in[k] = new_slot;
      end
      for (int k = 1; k < QUEUE_DEPTH; k++) begin
         if (cmd.insert_here && IDX_W'(k) > idx) slot_in[k] = slot_ff[k-1];
      end
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
         if (cmd.drop_here && IDX_W'(k) >= idx) slot_in[k] = slot_ff[k+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) slot_ff[k] <= slot_in[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         count_ff   <= '0;
         removed_ff <= '0;
         status_ff  <= STS_OK;
      end else begin
         scan_ff    <= scan_in;
         count_ff   <= count_in;
         removed_ff <= removed_in;
         status_ff  <= status_in;
      end
   end

   assign sts.op          = op_ff;
   assign sts.req_valid   = req_ch.valid;
   assign sts.full        = count_ff == CNT_W'(QUEUE_DEPTH);
   assign sts.empty       = count_ff == '0;
   assign sts.at_end      = scan_ff >= count_ff;
   assign sts.time_before = cur_slot.due_time < time_ff;
   assign sts.id_match    = cur_slot.object == id_ff;
   assign sts.limit_hit   = removed_ff == 2'(REMOVE_LIMIT);
   assign sts.out_free    = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = status_ff;
      rsp_in.removed_count = removed_ff;
      rsp_in.entry_count   = 5'(count_ff);
      if (count_ff != '0) begin
         rsp_in.head_valid     = 1'b1;
         rsp_in.head_time      = slot_ff[0].due_time;
         rsp_in.head_direction = slot_ff[0].direction;
         rsp_in.head_object    = id_to_port(slot_ff[0].object);
      end
   end

   assign rsp_valid_in = cmd.report ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.report) rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.removed_count  = rsp_ff.removed_count;
   assign rsp_ch.head_valid     = rsp_ff.head_valid;
   assign rsp_ch.head_time      = rsp_ff.head_time;
   assign rsp_ch.head_direction = rsp_ff.head_direction;
   assign rsp_ch.head_object    = rsp_ff.head_object;
   assign rsp_ch.entry_count    = rsp_ff.entry_count;

endmodule

// ===== design/toeq_ctrl.sv =====
// Operation sequencer for the event queue.
module toeq_ctrl
   import toeq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   state_in = ST_DECODE;
         ST_DECODE: begin
            unique case (sts.op)
               OP_INSERT: state_in = sts.full ? ST_REPORT : ST_INSERT;
               OP_POP:    state_in = ST_REPORT;
               OP_REMOVE: state_in = ST_REMOVE;
               OP_NOP:    state_in = ST_REPORT;
            endcase
         end
         ST_INSERT: begin
            if (sts.at_end || !sts.time_before) state_in = ST_REPORT;
         end
         ST_REMOVE: begin
            if (sts.limit_hit || sts.at_end) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
      endcase
      // hold in idle until a request transfer
      if (state_ff == ST_IDLE && !sts.req_valid) state_in = ST_IDLE;
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:   cmd.take_req = 1'b1;
         ST_DECODE: begin
            unique case (sts.op)
               OP_INSERT: cmd.set_full = sts.full;
               OP_POP: begin
                  cmd.set_empty = sts.empty;
                  cmd.drop_here = !sts.empty;
               end
               OP_REMOVE: cmd = '0;
               OP_NOP:    cmd = '0;
            endcase
         end
         ST_INSERT: begin
            if (sts.at_end || !sts.time_before) cmd.insert_here = 1'b1;
            else                                cmd.scan_step   = 1'b1;
         end
         ST_REMOVE: begin
            if (!sts.limit_hit && !sts.at_end) begin
               if (sts.id_match) cmd.drop_here = 1'b1;
               else              cmd.scan_step = 1'b1;
            end
         end
         ST_REPORT: cmd.report = sts.out_free;
      endcase
   end

endmodule

// ===== design/time_ordered_event_queue_top.sv =====
// Top level of the time-ordered event queue.
//
//   channel   dir  handshake                payload
//   req_ch    in   valid/ready, transfer    opcode, event_time, direction, object_id
//   rsp_ch    out  valid/ready, transfer    status, removed_count, head_*, entry_count
//
// One request at a time. The request is taken in idle, then decoded, then:
//   pop and no-op: report right after decode;
//   insert: report right after decode if full, else walk the slots until the
//     first slot with time not lower, or the end, and shift the entry in there;
//   remove: examine the slots in turn, deleting each matching object, until
//     two are deleted or the end is seen, then report.
// The walk goes over the sixteen slots by a single scan index.
// Reset clears the entry count and the response valid; slot contents stay stale
// and are never read past the entry count. A stalled response holds in its
// register and the next request is still taken; its own report waits for space.
module time_ordered_event_queue_top
   import toeq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   toeq_req_if.sink   req_ch,
   toeq_rsp_if.source rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: walks the slots one step per cycle
   toeq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // storage, compare logic and response register
   toeq_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .sts    (sts)
   );

endmodule

// ===== design/toeq_checker.sv =====
// Port-level checks for the event queue, bound to the top level.
module toeq_checker
   import toeq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [1:0]  rsp_removed_count,
   input logic        rsp_head_valid,
   input logic [31:0] rsp_head_time,
   input logic [4:0]  rsp_entry_count
);

   // one request in flight: ready drops after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_entry_count != 5'd0))
                 && (rsp_head_valid || rsp_head_time == 32'd0))
      else $error("head fields disagree with entry count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_FULL |->
         rsp_entry_count == 5'(QUEUE_DEPTH) && rsp_removed_count == 2'd0)
      else $error("full status with wrong count");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_EMPTY |->
         rsp_entry_count == 5'd0 && rsp_removed_count == 2'd0)
      else $error("empty status with entries");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count)
                                 && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind time_ordered_event_queue_top toeq_checker u_toeq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_removed_count (rsp_ch.removed_count),
   .rsp_head_valid    (rsp_ch.head_valid),
   .rsp_head_time     (rsp_ch.head_time),
   .rsp_entry_count   (rsp_ch.entry_count)
);
